[rtl/psm_pkg.sv]
// psm_pkg: shared types and constants for the polygon second moments unit
// holds the field widths, sequencer state and multiplier step codes
// no dependencies
`timescale 1ns / 1ps

package psm_pkg;

  // default parameter values
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 12;

  // fixed field widths
  localparam int unsigned IN_COORD_W = 12;
  localparam int unsigned CROSS_W    = 35;
  localparam int unsigned AREA_W     = 34;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned MOM_W      = 62;
  localparam int unsigned PROD_W     = 63;
  localparam int unsigned CNT_W      = 11;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_FINAL
  } state_e;

  // one multiplication per step; the final step drains the product register and adds the cross term to the area sum
  typedef enum logic [3:0] {
    STEP_PXQY,
    STEP_QXPY,
    STEP_PXPY,
    STEP_QXQY,
    STEP_PYPY,
    STEP_PYQY,
    STEP_QYQY,
    STEP_PXPX,
    STEP_PXQX,
    STEP_QXQX,
    STEP_XAXIS,
    STEP_YAXIS,
    STEP_PROD,
    STEP_FLUSH
  } step_e;

endpackage

[rtl/polygon_second_moments_unit.sv]
// polygon_second_moments_unit: exact area and second moments of a vertex stream
// one shared signed multiplier sequenced over fourteen steps per edge
// depends on psm_pkg
// flow: a first vertex transfers without a stall, and a lone marked vertex goes straight to
// the result load; every later vertex holds in_ready_o low while the multiplier steps for
// its edge run, so the next vertex is not taken until that edge is done; the marked last
// vertex holds it low over its edge, the closing edge and the result load (longer while an
// earlier result is not yet taken), after which its result is valid
// reset: asynchronous active low, clears sums, counters and the in-polygon flag
`timescale 1ns / 1ps

module polygon_second_moments_unit #(
  parameter int unsigned MAX_VERTICES = psm_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = psm_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [psm_pkg::IN_COORD_W-1:0] vertex_x_i,
  input  logic signed [psm_pkg::IN_COORD_W-1:0] vertex_y_i,
  input  logic                                  last_vertex_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [psm_pkg::AREA_W-1:0]     twice_area_o,
  output logic        [psm_pkg::MOM_W-1:0]      moment_about_x_scaled_o,
  output logic        [psm_pkg::MOM_W-1:0]      moment_about_y_scaled_o,
  output logic signed [psm_pkg::PROD_W-1:0]     product_moment_scaled_o,
  output logic        [psm_pkg::CNT_W-1:0]      vertex_total_o,
  output logic                                  too_many_vertices_o
);

  // operand width: holds the cross term and the product-moment factor
  localparam int unsigned PW  = 2 * COORD_BITS + 3;
  localparam int unsigned MW  = 2 * PW;
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned SW  = psm_pkg::SUM_W;
  localparam int unsigned XW  = psm_pkg::CROSS_W;
  localparam int unsigned NW  = psm_pkg::CNT_W;
  localparam logic [NW-1:0] MAX_CNT = NW'(MAX_VERTICES);

  psm_pkg::state_e state_q, state_d;
  psm_pkg::step_e  step_q, acc_sel_q;
  logic            acc_en_q;

  // vertex and edge endpoint registers
  logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CB-1:0] px_q, py_q, qx_q, qy_q;
  logic signed [CB-1:0] in_x, in_y;
  logic                 in_polygon_q, last_q, closing_q;
  logic [NW-1:0]        count_q;

  // per-edge terms and running sums
  logic signed [PW-1:0] c_q, fp_q, fy_q, fx_q;
  logic        [XW-1:0] cross_q;
  logic        [SW-1:0] xaxis_q, yaxis_q, prodsum_q;

  // shared multiplier
  logic signed [PW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] mul_p, prod_q;
  logic        [SW-1:0] prod_ext;

  // control strobes
  logic accept, start_edge, load_out, out_valid_q, neg;

  assign in_x = vertex_x_i[CB-1:0];
  assign in_y = vertex_y_i[CB-1:0];
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // sequencer next state and strobes
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    start_edge = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      psm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_polygon_q) begin
            start_edge = 1'b1;
            state_d    = psm_pkg::ST_EDGE;
          end else if (last_vertex_i) begin
            state_d = psm_pkg::ST_FINAL;
          end
        end
      end
      psm_pkg::ST_EDGE: begin
        if (step_q == psm_pkg::STEP_FLUSH) begin
          if (last_q && !closing_q) begin
            start_edge = 1'b1;
          end else if (last_q) begin
            state_d = psm_pkg::ST_FINAL;
          end else begin
            state_d = psm_pkg::ST_IDLE;
          end
        end
      end
      psm_pkg::ST_FINAL: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = psm_pkg::ST_IDLE;
        end
      end
      default: state_d = psm_pkg::ST_IDLE;
    endcase
  end

  // operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      psm_pkg::STEP_PXQY: begin mul_a = PW'(px_q); mul_b = PW'(qy_q); end
      psm_pkg::STEP_QXPY: begin mul_a = PW'(qx_q); mul_b = PW'(py_q); end
      psm_pkg::STEP_PXPY: begin mul_a = PW'(px_q); mul_b = PW'(py_q); end
      psm_pkg::STEP_QXQY: begin mul_a = PW'(qx_q); mul_b = PW'(qy_q); end
      psm_pkg::STEP_PYPY: begin mul_a = PW'(py_q); mul_b = PW'(py_q); end
      psm_pkg::STEP_PYQY: begin mul_a = PW'(py_q); mul_b = PW'(qy_q); end
      psm_pkg::STEP_QYQY: begin mul_a = PW'(qy_q); mul_b = PW'(qy_q); end
      psm_pkg::STEP_PXPX: begin mul_a = PW'(px_q); mul_b = PW'(px_q); end
      psm_pkg::STEP_PXQX: begin mul_a = PW'(px_q); mul_b = PW'(qx_q); end
      psm_pkg::STEP_QXQX: begin mul_a = PW'(qx_q); mul_b = PW'(qx_q); end
      psm_pkg::STEP_XAXIS: begin mul_a = fy_q; mul_b = c_q; end
      psm_pkg::STEP_YAXIS: begin mul_a = fx_q; mul_b = c_q; end
      psm_pkg::STEP_PROD: begin mul_a = fp_q; mul_b = c_q; end
      psm_pkg::STEP_FLUSH: begin mul_a = '0; mul_b = '0; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(SW - MW){prod_q[MW-1]}}, prod_q};
  assign neg      = cross_q[XW-1];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= psm_pkg::ST_IDLE;
      step_q       <= psm_pkg::STEP_PXQY;
      acc_sel_q    <= psm_pkg::STEP_PXQY;
      acc_en_q     <= 1'b0;
      in_polygon_q <= 1'b0;
      last_q       <= 1'b0;
      closing_q    <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_sel_q <= step_q;
      acc_en_q  <= (state_q == psm_pkg::ST_EDGE) && (step_q != psm_pkg::STEP_FLUSH);
      if (start_edge) begin
        step_q <= psm_pkg::STEP_PXQY;
      end else if (state_q == psm_pkg::ST_EDGE && step_q != psm_pkg::STEP_FLUSH) begin
        step_q <= psm_pkg::step_e'(step_q + 4'd1);
      end
      // vertex bookkeeping on each input transfer
      if (accept) begin
        last_q    <= last_vertex_i;
        closing_q <= 1'b0;
        if (!in_polygon_q) begin
          in_polygon_q <= 1'b1;
          count_q      <= NW'(1);
        end else if (count_q <= MAX_CNT) begin
          count_q <= count_q + NW'(1);
        end
      end else if (start_edge) begin
        closing_q <= 1'b1;
      end
      if (load_out) begin
        in_polygon_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cross_q   <= '0;
      xaxis_q   <= '0;
      yaxis_q   <= '0;
      prodsum_q <= '0;
    end else begin
      if (accept) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
        if (!in_polygon_q) begin
          first_x_q <= in_x;
          first_y_q <= in_y;
          cross_q   <= '0;
          xaxis_q   <= '0;
          yaxis_q   <= '0;
          prodsum_q <= '0;
        end
      end
      // fold the finished edge into the running sums
      if (acc_en_q) begin
        case (acc_sel_q)
          psm_pkg::STEP_XAXIS: xaxis_q   <= xaxis_q + prod_ext;
          psm_pkg::STEP_YAXIS: yaxis_q   <= yaxis_q + prod_ext;
          psm_pkg::STEP_PROD:  prodsum_q <= prodsum_q + prod_ext;
          default: ;
        endcase
      end
      if (state_q == psm_pkg::ST_EDGE && step_q == psm_pkg::STEP_FLUSH) begin
        cross_q <= cross_q + {{(XW - PW){c_q[PW-1]}}, c_q};
      end
    end
  end

  // edge endpoints, per-edge terms and product register
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (start_edge) begin
      c_q  <= '0;
      fp_q <= '0;
      fy_q <= '0;
      fx_q <= '0;
      if (accept) begin
        px_q <= prev_x_q;
        py_q <= prev_y_q;
        qx_q <= in_x;
        qy_q <= in_y;
      end else begin
        px_q <= qx_q;
        py_q <= qy_q;
        qx_q <= first_x_q;
        qy_q <= first_y_q;
      end
    end else if (acc_en_q) begin
      case (acc_sel_q)
        psm_pkg::STEP_PXQY: begin
          c_q  <= c_q + prod_q[PW-1:0];
          fp_q <= fp_q + prod_q[PW-1:0];
        end
        psm_pkg::STEP_QXPY: begin
          c_q  <= c_q - prod_q[PW-1:0];
          fp_q <= fp_q + prod_q[PW-1:0];
        end
        psm_pkg::STEP_PXPY, psm_pkg::STEP_QXQY: begin
          fp_q <= fp_q + {prod_q[PW-2:0], 1'b0};
        end
        psm_pkg::STEP_PYPY, psm_pkg::STEP_PYQY, psm_pkg::STEP_QYQY: begin
          fy_q <= fy_q + prod_q[PW-1:0];
        end
        psm_pkg::STEP_PXPX, psm_pkg::STEP_PXQX, psm_pkg::STEP_QXQX: begin
          fx_q <= fx_q + prod_q[PW-1:0];
        end
        default: ;
      endcase
    end
  end

  // result register, orientation made positive
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      twice_area_o <= neg ? psm_pkg::AREA_W'(XW'(0) - cross_q)
                          : cross_q[psm_pkg::AREA_W-1:0];
      moment_about_x_scaled_o <= neg ? psm_pkg::MOM_W'(SW'(0) - xaxis_q)
                                     : xaxis_q[psm_pkg::MOM_W-1:0];
      moment_about_y_scaled_o <= neg ? psm_pkg::MOM_W'(SW'(0) - yaxis_q)
                                     : yaxis_q[psm_pkg::MOM_W-1:0];
      product_moment_scaled_o <= neg ? psm_pkg::PROD_W'(SW'(0) - prodsum_q)
                                     : prodsum_q[psm_pkg::PROD_W-1:0];
      vertex_total_o      <= (count_q > MAX_CNT) ? MAX_CNT : count_q;
      too_many_vertices_o <= (count_q > MAX_CNT);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT + NW'(1))
    else $error("vertex count passed its saturation value");

  a_flag_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_many_vertices_o |-> vertex_total_o == MAX_CNT)
    else $error("overflow flag without saturated vertex total");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == psm_pkg::ST_FINAL)
    else $error("result raised outside the final step");

  a_flush_drains_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psm_pkg::ST_EDGE && step_q == psm_pkg::STEP_FLUSH)
      |-> (acc_en_q && acc_sel_q == psm_pkg::STEP_PROD))
    else $error("edge flushed before the product moment was accumulated");

  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_polygon_q |=> count_q == NW'(1))
    else $error("first vertex did not restart the count");

endmodule
